/* hw/rtl/keyword_coordinate_stream_parser_assert.svh */
// Assertion macros for the keyword coordinate stream parser checks.
`ifndef KEYWORD_COORDINATE_STREAM_PARSER_ASSERT_SVH
`define KEYWORD_COORDINATE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and held off while in reset.
`define KCSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kcsp check failed");

// Next-cycle implication, sampled on i_clk and held off while in reset.
`define KCSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kcsp check failed");

`endif

/* hw/rtl/kcsp_pkg.sv */
// Shared types, character codes and constants for the coordinate stream parser.
`timescale 1ns / 1ps
`default_nettype none

package kcsp_pkg;

    localparam int ACC_W = 41;
    localparam int SUM_W = ACC_W + 5;
    localparam logic [ACC_W-1:0] ACC_LIMIT = {1'b0, {(ACC_W-1){1'b1}}};

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_UPPER_L = 8'h4C;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        KW_NONE = 2'd0,
        KW_STOP = 2'd1,
        KW_LON  = 2'd2,
        KW_LAT  = 2'd3
    } t_keyword;

    // Decoded view of the byte being processed.
    typedef struct packed {
        logic is_colon;
        logic is_comma;
        logic is_minus;
        logic is_period;
        logic at_start;
    } t_byte_ctl;

    // Message tracker status seen by the rest of the datapath.
    typedef struct packed {
        logic     at_start;
        t_keyword keyword;
    } t_msg_status;

    // Powers of ten, evaluated at elaboration only.
    function automatic longint unsigned pow10(int e);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < e; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/kcsp_keyword_track.sv */
// Message position tracking and keyword selection for the parser.
`timescale 1ns / 1ps
`default_nettype none

module kcsp_keyword_track (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic [7:0]            i_byte,
    output kcsp_pkg::t_msg_status      o_status
);
    import kcsp_pkg::*;

    logic [1:0] r_pos,       n_pos;
    logic [7:0] r_first,     n_first;
    logic       r_second_o,  n_second_o;
    t_keyword   r_kw,        n_kw;

    always_comb begin
        n_pos      = r_pos;
        n_first    = r_first;
        n_second_o = r_second_o;
        n_kw       = r_kw;
        if (i_byte == CH_COLON) begin
            n_kw = KW_STOP;
            if (r_pos != 2'd0 && r_first == CH_UPPER_L) begin
                n_kw = (r_pos == 2'd2 && r_second_o) ? KW_LON : KW_LAT;
            end
            n_pos      = 2'd0;
            n_first    = '0;
            n_second_o = 1'b0;
        end else if (i_byte == CH_COMMA) begin
            n_pos      = 2'd0;
            n_first    = '0;
            n_second_o = 1'b0;
        end else begin
            if (r_pos == 2'd0) begin
                n_first = i_byte;
            end
            if (r_pos == 2'd1) begin
                n_second_o = (i_byte == CH_LOWER_O);
            end
            if (r_pos != 2'd2) begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 2'd0;
            r_first    <= '0;
            r_second_o <= 1'b0;
            r_kw       <= KW_NONE;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_first    <= n_first;
            r_second_o <= n_second_o;
            r_kw       <= n_kw;
        end
    end

    assign o_status.at_start = (r_pos == 2'd0);
    assign o_status.keyword  = r_kw;

endmodule

`default_nettype wire

/* hw/rtl/kcsp_number_accum.sv */
// Fixed-point decimal accumulator with sign, fraction count and saturation.
`timescale 1ns / 1ps
`default_nettype none

module kcsp_number_accum #(
    parameter int FRAC_DIGITS = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [7:0]                    i_byte,
    input  wire kcsp_pkg::t_byte_ctl           i_ctl,
    output logic signed [kcsp_pkg::ACC_W-1:0]  o_value
);
    import kcsp_pkg::*;

    localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int SCALE_N = 1 << CNT_W;
    localparam int SCALE_W = $clog2(pow10(FRAC_DIGITS)) + 2;
    localparam int PROD_W  = SCALE_W + 9;
    localparam logic [SCALE_W-1:0] INT_SCALE = SCALE_W'(pow10(FRAC_DIGITS));
    localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(ACC_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_NEG = -SUM_W'(ACC_LIMIT);

    logic                     r_neg,    n_neg;
    logic                     r_period, n_period;
    logic [CNT_W-1:0]         r_cnt,    n_cnt;
    logic signed [ACC_W-1:0]  r_acc,    n_acc;

    logic [SCALE_W-1:0]         frac_scale [SCALE_N];
    logic signed [8:0]          digit;
    logic signed [SCALE_W-1:0]  scale;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    acc_ext;
    logic signed [SUM_W-1:0]    base;
    logic signed [SUM_W-1:0]    sum;
    logic signed [ACC_W-1:0]    sum_sat;

    // Weight of the next fraction digit, indexed by digits already taken.
    for (genvar g = 0; g < SCALE_N; g++) begin : g_scale
        if (g < FRAC_DIGITS) begin : g_used
            assign frac_scale[g] = SCALE_W'(pow10(FRAC_DIGITS - 1 - g));
        end else begin : g_unused
            assign frac_scale[g] = '0;
        end
    end

    assign digit   = $signed({1'b0, i_byte}) - $signed({1'b0, CH_ZERO});
    assign scale   = $signed(r_period ? frac_scale[r_cnt] : INT_SCALE);
    assign prod    = digit * scale;
    assign acc_ext = SUM_W'(r_acc);
    assign base    = r_period ? acc_ext : (acc_ext <<< 3) + (acc_ext <<< 1);
    assign sum     = base + SUM_W'(prod);

    always_comb begin
        if (sum > LIM_POS) begin
            sum_sat = ACC_W'(LIM_POS);
        end else if (sum < LIM_NEG) begin
            sum_sat = ACC_W'(LIM_NEG);
        end else begin
            sum_sat = ACC_W'(sum);
        end
    end

    always_comb begin
        n_neg    = r_neg;
        n_period = r_period;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        if (i_ctl.is_colon || i_ctl.is_comma) begin
            n_neg    = 1'b0;
            n_period = 1'b0;
            n_cnt    = '0;
            n_acc    = '0;
        end else if (i_ctl.at_start && i_ctl.is_minus) begin
            n_neg = 1'b1;
        end else if (r_period) begin
            if (r_cnt < CNT_W'(FRAC_DIGITS)) begin
                n_cnt = r_cnt + 1'b1;
                n_acc = sum_sat;
            end
        end else if (i_ctl.is_period) begin
            n_period = 1'b1;
        end else begin
            n_acc = sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg    <= 1'b0;
            r_period <= 1'b0;
            r_cnt    <= '0;
            r_acc    <= '0;
        end else if (i_en) begin
            r_neg    <= n_neg;
            r_period <= n_period;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
        end
    end

    // Signed value of the number so far, as stored when a comma ends it.
    assign o_value = r_neg ? -r_acc : r_acc;

endmodule

`default_nettype wire

/* hw/rtl/keyword_coordinate_stream_parser.sv */
// Top level of the keyword coordinate stream parser.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | i_valid / o_ready  | i_rx_byte
//  output   | o_valid / i_ready  | o_latitude_done, o_latitude_value,
//           |                    | o_longitude_value
//
// One received byte is taken per clock cycle while the output is not stalled,
// and every byte gives exactly one output transaction. A byte is first
// captured in the input register, is then processed by the keyword tracker
// and the number accumulator, and its result lands in the output register.
// The accumulator's multiply-add is combinational. Reset is synchronous and
// active low; it clears the keyword, the number in progress and both stored
// coordinates. A stall on the output holds the output register and any byte
// in the input register, and input is refused only while the input register
// holds a byte that cannot move on.
`timescale 1ns / 1ps
`default_nettype none

module keyword_coordinate_stream_parser #(
    parameter int FRAC_DIGITS = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_rx_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_latitude_done,
    output logic signed [kcsp_pkg::ACC_W-1:0]  o_latitude_value,
    output logic signed [kcsp_pkg::ACC_W-1:0]  o_longitude_value
);
    import kcsp_pkg::*;

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Output register, which also holds the stored coordinates.
    logic                    r_out_vld;
    logic                    r_complete, n_complete;
    logic signed [ACC_W-1:0] r_lat,      n_lat;
    logic signed [ACC_W-1:0] r_lon,      n_lon;

    logic                    advance;
    logic                    process;
    t_msg_status             msg_status;
    t_byte_ctl               byte_ctl;
    logic signed [ACC_W-1:0] number_value;

    // The output register can take a new result when it is empty or is being
    // drained in this cycle; the input register follows the same rule.
    assign advance = !r_out_vld || i_ready;
    assign process = r_in_vld && advance;
    assign o_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Decode the byte under processing once for the accumulator.
    assign byte_ctl.is_colon  = (r_in_byte == CH_COLON);
    assign byte_ctl.is_comma  = (r_in_byte == CH_COMMA);
    assign byte_ctl.is_minus  = (r_in_byte == CH_MINUS);
    assign byte_ctl.is_period = (r_in_byte == CH_PERIOD);
    assign byte_ctl.at_start  = msg_status.at_start;

    kcsp_keyword_track u_keyword (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (process),
        .i_byte   (r_in_byte),
        .o_status (msg_status)
    );

    kcsp_number_accum #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_number (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (process),
        .i_byte  (r_in_byte),
        .i_ctl   (byte_ctl),
        .o_value (number_value)
    );

    // A comma commits the number to whichever coordinate the last keyword
    // selected; a latitude also raises the completion flag for this
    // transaction. With no keyword or a stop keyword the number is dropped.
    always_comb begin
        n_lat      = r_lat;
        n_lon      = r_lon;
        n_complete = 1'b0;
        if (byte_ctl.is_comma) begin
            case (msg_status.keyword)
                KW_LON: begin
                    n_lon = number_value;
                end
                KW_LAT: begin
                    n_lat      = number_value;
                    n_complete = 1'b1;
                end
                default: begin
                    n_complete = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_complete <= 1'b0;
            r_lat      <= '0;
            r_lon      <= '0;
        end else begin
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (process) begin
                r_complete <= n_complete;
                r_lat      <= n_lat;
                r_lon      <= n_lon;
            end
        end
    end

    assign o_valid           = r_out_vld;
    assign o_latitude_done   = r_complete;
    assign o_latitude_value  = r_lat;
    assign o_longitude_value = r_lon;

endmodule

`default_nettype wire

/* hw/rtl/kcsp_port_checker.sv */
// Port-level checks for the coordinate stream parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "keyword_coordinate_stream_parser_assert.svh"

module kcsp_port_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_latitude_done,
    input wire logic signed [kcsp_pkg::ACC_W-1:0] o_latitude_value,
    input wire logic signed [kcsp_pkg::ACC_W-1:0] o_longitude_value
);
    import kcsp_pkg::*;

    logic [2*ACC_W:0] out_payload;
    logic             out_taken;

    assign out_payload = {o_latitude_done, o_latitude_value, o_longitude_value};
    assign out_taken   = o_valid && i_ready;

    // A held output transaction keeps its payload.
    `KCSP_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(out_payload))

    // Nothing is offered straight out of reset.
    `KCSP_ASSERT_NOW(a_reset_empty, $rose(i_rst_n), !o_valid)

    // One byte can update at most one of the two stored coordinates.
    `KCSP_ASSERT_NOW(a_one_store, o_valid && $past(out_taken), $stable(o_latitude_value) || $stable(o_longitude_value))

    // A completed latitude never comes with a new longitude.
    `KCSP_ASSERT_NOW(a_complete_lat, o_valid && o_latitude_done && $past(out_taken), $stable(o_longitude_value))

endmodule

bind keyword_coordinate_stream_parser kcsp_port_checker u_kcsp_port_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_latitude_done   (o_latitude_done),
    .o_latitude_value  (o_latitude_value),
    .o_longitude_value (o_longitude_value)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the keyword coordinate stream parser.
`timescale 1ns / 1ps

module testbench;
    import kcsp_pkg::*;

    localparam int FRAC = 7;
    // Cycles without any transaction on either side before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // The long receiver hold-off, and how many results are checked before it starts.
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int HOLD_OFF_AFTER = 150;
    localparam int RANDOM_BYTES = 400;
    localparam longint COORD_MAX = longint'(ACC_LIMIT);
    // "-1.5" followed by a second period, four nines, a 0x00 byte and one dropped byte.
    localparam longint PROBE_LONGITUDE = -14899942;

    typedef struct packed {
        logic                    complete;
        logic signed [ACC_W-1:0] latitude;
        logic signed [ACC_W-1:0] longitude;
    } t_coord_fix;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_coord_fix want;
    } t_probe_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic [7:0]              i_rx_byte = 8'h00;
    logic                    i_ready = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic                    o_latitude_done;
    logic signed [ACC_W-1:0] o_latitude_value;
    logic signed [ACC_W-1:0] o_longitude_value;

    keyword_coordinate_stream_parser #(
        .FRAC_DIGITS(FRAC)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_latitude_done   (o_latitude_done),
        .o_latitude_value  (o_latitude_value),
        .o_longitude_value (o_longitude_value)
    );

    always #1 i_clk = ~i_clk;

    // Parser state as the testbench sees it, starting from its reset values.
    logic [1:0] msg_bytes = 2'd0;
    logic [7:0] msg_lead = 8'h00;
    bit         msg_second_o = 1'b0;
    t_keyword   keyword_sel = KW_NONE;
    bit         num_negative = 1'b0;
    bit         num_fraction = 1'b0;
    int         fraction_digits = 0;
    longint     num_acc = 0;
    longint     stored_lat = 0;
    longint     stored_lon = 0;

    t_coord_fix awaited_fixes[$];
    t_probe_row probe_rows[$];
    logic [7:0] sentence[$];
    int         fixes_checked = 0;
    int         quiet_cycles = 0;
    bit         any_failure = 1'b0;

    function automatic longint ten_pow(int e);
        longint r;
        r = 1;
        for (int i = 0; i < e; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    function automatic longint saturate(longint v);
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        if (v < -COORD_MAX) begin
            return -COORD_MAX;
        end
        return v;
    endfunction

    // Both delimiters throw away the message in progress; this leaves the keyword alone.
    function void start_new_message();
        msg_bytes = 2'd0;
        msg_lead = 8'h00;
        msg_second_o = 1'b0;
        num_negative = 1'b0;
        num_fraction = 1'b0;
        fraction_digits = 0;
        num_acc = 0;
    endfunction

    // Advances the parser state by one byte and gives the result it must produce.
    task automatic parse_byte(input logic [7:0] rx, output t_coord_fix fix);
        longint   digit;
        longint   signed_value;
        t_keyword kw;
        fix.complete = 1'b0;
        if (rx == CH_COLON) begin
            kw = KW_STOP;
            if (msg_bytes >= 2'd1 && msg_lead == CH_UPPER_L) begin
                kw = (msg_bytes >= 2'd2 && msg_second_o) ? KW_LON : KW_LAT;
            end
            keyword_sel = kw;
            start_new_message();
        end else if (rx == CH_COMMA) begin
            signed_value = num_negative ? -num_acc : num_acc;
            if (keyword_sel == KW_LON) begin
                stored_lon = signed_value;
            end else if (keyword_sel == KW_LAT) begin
                stored_lat = signed_value;
                fix.complete = 1'b1;
            end
            start_new_message();
        end else begin
            // Anything that is not a delimiter, sign or first period is a digit,
            // even when its code lies far outside '0' to '9'.
            digit = longint'(rx) - 48;
            if (msg_bytes == 2'd0) begin
                msg_lead = rx;
            end else if (msg_bytes == 2'd1) begin
                msg_second_o = (rx == CH_LOWER_O);
            end
            if (msg_bytes == 2'd0 && rx == CH_MINUS) begin
                num_negative = 1'b1;
            end else if (num_fraction) begin
                // Fraction digits past the precision are truncated away.
                if (fraction_digits < FRAC) begin
                    fraction_digits++;
                    num_acc = saturate(num_acc + digit * ten_pow(FRAC - fraction_digits));
                end
            end else if (rx == CH_PERIOD) begin
                num_fraction = 1'b1;
            end else begin
                num_acc = saturate(num_acc * 10 + digit * ten_pow(FRAC));
            end
            if (msg_bytes < 2'd2) begin
                msg_bytes++;
            end
        end
        fix.latitude = stored_lat[ACC_W-1:0];
        fix.longitude = stored_lon[ACC_W-1:0];
    endtask

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end
        if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        if (pick < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function void add_probe(logic [7:0] rx, bit typed, bit cc, longint lat, longint lon);
        t_probe_row row;
        row.rx = rx;
        row.typed = typed;
        row.want.complete = cc;
        row.want.latitude = lat[ACC_W-1:0];
        row.want.longitude = lon[ACC_W-1:0];
        probe_rows.push_back(row);
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_COLON || b == CH_COMMA) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    // Keyword messages lean towards longitude and latitude so that numbers get stored.
    function void compose_keyword();
        int         pick;
        int         tail;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            sentence.push_back(CH_UPPER_L);
            sentence.push_back(CH_LOWER_O);
            tail = $urandom_range(0, 2);
            repeat (tail) sentence.push_back(body_byte());
        end else if (pick < 70) begin
            sentence.push_back(CH_UPPER_L);
            b = body_byte();
            while (b == CH_LOWER_O) begin
                b = body_byte();
            end
            sentence.push_back(b);
        end else if (pick < 80) begin
            sentence.push_back(CH_UPPER_L);
        end else if (pick >= 90) begin
            b = body_byte();
            while (b == CH_UPPER_L) begin
                b = body_byte();
            end
            sentence.push_back(b);
            sentence.push_back(body_byte());
        end
        sentence.push_back(CH_COLON);
    endfunction

    // A signed decimal number; a few are long enough to saturate, and the odd
    // character is replaced by an arbitrary byte or a further period.
    function void compose_number();
        int style;
        int int_digits;
        int frac_count;
        style = $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 1) begin
            sentence.push_back(CH_MINUS);
        end
        int_digits = (style < 2) ? $urandom_range(7, 14) : $urandom_range(0, 4);
        for (int i = 0; i < int_digits; i++) begin
            if (style == 1) begin
                sentence.push_back(8'h00);
            end else begin
                sentence.push_back(($urandom_range(0, 9) == 0) ? body_byte() : digit_char());
            end
        end
        if ($urandom_range(0, 9) < 7) begin
            sentence.push_back(CH_PERIOD);
            frac_count = $urandom_range(0, 10);
            for (int i = 0; i < frac_count; i++) begin
                case ($urandom_range(0, 11))
                    0: begin
                        sentence.push_back(CH_PERIOD);
                    end
                    1: begin
                        sentence.push_back(body_byte());
                    end
                    default: begin
                        sentence.push_back(digit_char());
                    end
                endcase
            end
        end
        sentence.push_back(CH_COMMA);
    endfunction

    // Offers one byte and waits for its transaction, then records what must come out.
    task automatic offer_byte(input logic [7:0] rx, input bit typed, input t_coord_fix want,
                              input bit calm);
        int         gap;
        t_coord_fix predicted;
        gap = calm ? 0 : idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        parse_byte(rx, predicted);
        awaited_fixes.push_back(typed ? want : predicted);
    endtask

    initial begin : stimulus
        t_probe_row row;
        logic [7:0] b;
        int         sent;
        int         pick;

        // Directed bytes. A comma with no keyword yet stores nothing.
        add_probe(CH_COMMA, 1, 0, 0, 0);
        // An "Lo" keyword selects longitude.
        add_probe(CH_UPPER_L, 0, 0, 0, 0);
        add_probe(CH_LOWER_O, 0, 0, 0, 0);
        add_probe(CH_COLON, 1, 0, 0, 0);
        // Negative longitude with a second period, a 0x00 fraction digit and
        // one fraction digit too many.
        add_probe(CH_MINUS, 0, 0, 0, 0);
        add_probe(8'(CH_ZERO + 1), 0, 0, 0, 0);
        add_probe(CH_PERIOD, 0, 0, 0, 0);
        add_probe(8'(CH_ZERO + 5), 0, 0, 0, 0);
        add_probe(CH_PERIOD, 0, 0, 0, 0);
        repeat (4) add_probe(8'(CH_ZERO + 9), 0, 0, 0, 0);
        add_probe(8'h00, 0, 0, 0, 0);
        add_probe(8'hFF, 0, 0, 0, 0);
        add_probe(CH_COMMA, 1, 0, 0, PROBE_LONGITUDE);
        // A bare colon selects stop; the empty number that follows goes nowhere.
        add_probe(CH_COLON, 1, 0, 0, PROBE_LONGITUDE);
        add_probe(CH_COMMA, 1, 0, 0, PROBE_LONGITUDE);
        // "L:" selects latitude, and four 0xFF digits drive it into saturation.
        add_probe(CH_UPPER_L, 0, 0, 0, 0);
        add_probe(CH_COLON, 0, 0, 0, 0);
        repeat (4) add_probe(8'hFF, 0, 0, 0, 0);
        add_probe(CH_COMMA, 1, 1, COORD_MAX, PROBE_LONGITUDE);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[i]) begin
            row = probe_rows[i];
            offer_byte(row.rx, row.typed, row.want, 1'b0);
        end

        // Random sentences: mostly well-formed keywords and numbers, some noise.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                compose_keyword();
            end else if (pick < 88) begin
                compose_number();
            end else begin
                repeat ($urandom_range(1, 6)) sentence.push_back(8'($urandom_range(0, 255)));
            end
            while (sentence.size() > 0) begin
                b = sentence.pop_front();
                // Every fourth block of forty bytes goes out without gaps.
                offer_byte(b, 1'b0, '0, ((sent / 40) % 4) == 3);
                sent++;
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_fixes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (!any_failure) begin
            $display("** keyword_coordinate_stream_parser: PASSED **");
        end else begin
            $display("** keyword_coordinate_stream_parser: FAILED **");
        end
        $finish;
    end

    // The receiver stalls at random, with calm stretches, and once holds off
    // long enough for the pipeline to fill and refuse input.
    initial begin : result_sink
        int stall;
        int sink_cycles;
        bit held_off;
        sink_cycles = 0;
        held_off = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && fixes_checked >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = (((sink_cycles / 64) % 4) == 1) ? 0 : idle_gap();
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            sink_cycles += stall + 1;
        end
    end

    // Every result transaction is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_fixes
        t_coord_fix want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_fixes.size() == 0) begin
                $error("result transaction with no byte waiting for it");
                any_failure = 1'b1;
            end else begin
                want = awaited_fixes.pop_front();
                if (o_latitude_done !== want.complete) begin
                    $error("latitude_done: expected %0d, got %0d",
                           want.complete, o_latitude_done);
                    any_failure = 1'b1;
                end
                if (o_latitude_value !== want.latitude) begin
                    $error("latitude_value: expected %0d, got %0d",
                           $signed(want.latitude), o_latitude_value);
                    any_failure = 1'b1;
                end
                if (o_longitude_value !== want.longitude) begin
                    $error("longitude_value: expected %0d, got %0d",
                           $signed(want.longitude), o_longitude_value);
                    any_failure = 1'b1;
                end
                fixes_checked++;
            end
        end
    end

    // Gives up when neither channel has completed a transaction for too long.
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("** keyword_coordinate_stream_parser: FAILED **");
                    $finish;
                end
            end
        end
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/kcsp_pkg.sv
hw/rtl/kcsp_keyword_track.sv
hw/rtl/kcsp_number_accum.sv
hw/rtl/keyword_coordinate_stream_parser.sv
hw/rtl/kcsp_port_checker.sv
bench/testbench.sv
